@@ rtl/gic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gic_pkg - shared types and constants of the gamepad input conditioner
// Result kinds, slot layout of one poll, divider sizing and the button map.
// ----------------------------------------------------------------------------
package gic_pkg;

	localparam int NUM_PLAYERS = 4;

	// Restoring divider: quotient never exceeds 2^15, so 16 bits / 16 steps.
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int DIV_W     = 33;

	// Result slots of one poll: attach/detach, four analog results, 16 buttons.
	localparam int SLOT_FIRST = 0;
	localparam int SLOT_LSTK  = 1;
	localparam int SLOT_RSTK  = 2;
	localparam int SLOT_LTRG  = 3;
	localparam int SLOT_RTRG  = 4;
	localparam int SLOT_BTN   = 5;
	localparam int NUM_SLOTS  = SLOT_BTN + 16;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);

	// Four divider operands: the stick axes (left x/y, right x/y).
	localparam int NUM_OPS = 4;
	localparam int OP_W    = $clog2(NUM_OPS);

	localparam logic [0:0] CFG_DEAD_ZONE  = 1'b0;
	localparam logic [0:0] CFG_TRIG_LEVEL = 1'b1;

	localparam logic [15:0] DEAD_ZONE_RST  = 16'd26214;
	localparam logic [7:0]  TRIG_LEVEL_RST = 8'd5;
	localparam logic [32:0] FULL_SCALE     = 33'h1_0000_0000;

	typedef enum logic [2:0] {
		KIND_ATTACH = 3'd0,
		KIND_DETACH = 3'd1,
		KIND_LSTICK = 3'd2,
		KIND_RSTICK = 3'd3,
		KIND_LTRIG  = 3'd4,
		KIND_RTRIG  = 3'd5,
		KIND_BUTTON = 3'd6
	} kind_t;

	// Raw pad bit behind each derived button; triggers have no raw bit.
	localparam logic [15:0] PAD_MASK [16] = '{
		16'h0010, 16'h0100, 16'h0000, 16'h0200, 16'h0000, 16'h1000, 16'h2000, 16'h4000,
		16'h8000, 16'h0004, 16'h0001, 16'h0008, 16'h0002, 16'h0020, 16'h0040, 16'h0080
	};

	function automatic logic [15:0] map_buttons(input logic [15:0] bits,
	                                            input logic lt_on,
	                                            input logic rt_on);
		logic [15:0] d;
		d = '0;
		for (int i = 0; i < 16; i++) begin
			d[i] = |(bits & PAD_MASK[i]);
		end
		d[2] = d[2] | lt_on;
		d[4] = d[4] | rt_on;
		return d;
	endfunction

endpackage
`default_nettype wire

@@ rtl/gic_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gic_div - shared restoring divider
// One quotient bit per cycle; dividend must not exceed divisor, and the
// dividend is taken as scaled by 2^15.
// ----------------------------------------------------------------------------
module gic_div import gic_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DIV_W-1:0]   dividend,
	input  wire logic [DIV_W-1:0]   divisor,
	output logic                    done,
	output logic [DIV_STEPS-1:0]    quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W:0]       rem_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic                 ge;
	logic [DIV_W:0]       rem_next;

	assign ge       = rem_q >= {1'b0, dvs_q};
	assign rem_next = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below the divisor, so the shift never overflows
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= {rem_next[DIV_W-1:0], 1'b0};
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ rtl/gamepad_input_conditioner.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_input_conditioner - gamepad poll conditioning
// Dead zone and rescale of both sticks, trigger scaling, attach/detach and
// button change events for up to four players.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) carries one poll per item. in_stall
//    is high after acceptance until the last result of that poll has been
//    loaded into the output register; a poll with no results never raises it.
//  - Output channel (out_valid/out_stall) carries results, 0 to 21 per poll,
//    in order: attach or detach, left stick, right stick, left trigger,
//    right trigger, then button changes in ascending index; last marks the
//    final one. The output register holds while out_stall is high.
//  - A connected poll runs four divisions (the four stick axes) on one
//    shared 16-step divider (ST_START, then ST_WAIT until done), then
//    walks the result slot positions up to the last result (21 slots, at
//    most one result per cycle while out_stall allows). Triggers are
//    scaled by shift and add as their result loads. A detach poll emits
//    only its detach result; an absent pad that was never present emits none.
//  - Reset clears pad presence and button history of all players and loads
//    the default dead zone slider and trigger level.
//  - cfg_we writes register cfg_index (0 dead zone slider, 1 trigger level)
//    from cfg_data; write only while idle.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner import gic_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         player,
	input  wire logic               connected,
	input  wire logic [15:0]        button_bits,
	input  wire logic [7:0]         left_trigger,
	input  wire logic [7:0]         right_trigger,
	input  wire logic signed [15:0] left_stick_x,
	input  wire logic signed [15:0] left_stick_y,
	input  wire logic signed [15:0] right_stick_x,
	input  wire logic signed [15:0] right_stick_y,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              kind,
	output logic [1:0]              player_res,
	output logic signed [15:0]      value_x,
	output logic signed [15:0]      value_y,
	output logic [3:0]              button_index,
	output logic                    button_pressed,
	output logic                    last,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] slider_q;
	logic [7:0]  level_q;

	// per-player history
	logic [15:0] prev_q    [NUM_PLAYERS];
	logic        present_q [NUM_PLAYERS];

	// latched poll
	logic [1:0]        player_q;
	logic              detach_q;
	logic signed [15:0] axis_q [4];
	logic [7:0]        trig_q [2];
	logic [31:0]       dz_q;
	logic [15:0]       derived_q;
	logic [NUM_SLOTS-1:0] en_q;

	// divide sequencing
	logic [OP_W-1:0]   op_q;
	logic              zero_q;
	logic              neg_q;
	logic signed [15:0] val_q [NUM_OPS];
	logic [SLOT_W-1:0] pos_q;

	// output register
	logic               out_valid_q;
	kind_t              kind_q;
	logic [1:0]         player_res_q;
	logic signed [15:0] value_x_q;
	logic signed [15:0] value_y_q;
	logic [3:0]         button_index_q;
	logic               button_pressed_q;
	logic               last_q;

	logic in_acc;
	logic pl_ok;
	logic lt_on;
	logic rt_on;
	logic [15:0] derived;
	logic [15:0] diff;
	logic        was_present;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign pl_ok    = (32'(player) < 32'(NUM_PLAYERS));
	assign lt_on    = left_trigger > level_q;
	assign rt_on    = right_trigger > level_q;
	assign derived  = map_buttons(button_bits, lt_on, rt_on);
	assign diff     = derived ^ prev_q[player];
	assign was_present = present_q[player];

	// operand setup for the divider
	logic signed [15:0] raw;
	logic [16:0]        raw_ext;
	logic [16:0]        mag;
	logic [DIV_W-1:0]   m_full;
	logic [DIV_W-1:0]   dz_ext;
	logic               op_zero;
	logic               op_neg;
	logic [DIV_W-1:0]   div_a;
	logic [DIV_W-1:0]   div_d;
	logic               div_start;
	logic               div_done;
	logic [DIV_STEPS-1:0] div_q;

	assign raw      = axis_q[op_q];
	assign raw_ext  = {raw[15], raw};
	assign mag      = raw[15] ? (17'd0 - raw_ext) : raw_ext;
	assign m_full   = {mag[15:0], 17'b0};
	assign dz_ext   = {1'b0, dz_q};

	assign op_zero  = m_full <= dz_ext;
	assign op_neg   = raw[15];
	assign div_a    = m_full - dz_ext;
	assign div_d    = FULL_SCALE - dz_ext;

	assign div_start = (state_q == ST_START);

	gic_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	// sign, saturation and dead zone applied to the quotient
	logic signed [15:0] op_val;
	always_comb begin
		if (zero_q) begin
			op_val = '0;
		end else if (neg_q) begin
			op_val = 16'(17'd0 - {1'b0, div_q});
		end else if (div_q[15]) begin
			op_val = 16'sh7FFF;
		end else begin
			op_val = div_q;
		end
	end

	// t * 32768 / 255 = u + u / 255 with u = t << 7; u / 255 as (u + (u >> 8) + 1) >> 8
	function automatic logic signed [15:0] trig_q15(input logic [7:0] t);
		logic [14:0] u;
		logic [15:0] s;
		logic [15:0] q;
		u = {t, 7'b0};
		s = 16'(u) + 16'(u[14:8]) + 16'd1;
		q = 16'(u) + 16'(s[15:8]);
		return q[15] ? 16'sh7FFF : q;
	endfunction

	// emission slot payload
	logic [NUM_SLOTS-1:0] rest;
	logic                 slot_last;
	logic                 out_free;
	logic                 do_load;
	kind_t                slot_kind;
	logic signed [15:0]   slot_x;
	logic signed [15:0]   slot_y;
	logic [3:0]           slot_idx;
	logic                 slot_pr;

	assign rest      = en_q >> pos_q;
	assign slot_last = (rest[NUM_SLOTS-1:1] == '0);
	assign out_free  = !out_valid_q || !out_stall;
	assign do_load   = (state_q == ST_EMIT) && en_q[pos_q] && out_free;

	always_comb begin
		slot_x   = '0;
		slot_y   = '0;
		slot_idx = '0;
		slot_pr  = 1'b0;
		case (pos_q)
			SLOT_W'(SLOT_FIRST): begin
				slot_kind = detach_q ? KIND_DETACH : KIND_ATTACH;
			end
			SLOT_W'(SLOT_LSTK): begin
				slot_kind = KIND_LSTICK;
				slot_x    = val_q[0];
				slot_y    = val_q[1];
			end
			SLOT_W'(SLOT_RSTK): begin
				slot_kind = KIND_RSTICK;
				slot_x    = val_q[2];
				slot_y    = val_q[3];
			end
			SLOT_W'(SLOT_LTRG): begin
				slot_kind = KIND_LTRIG;
				slot_x    = trig_q15(trig_q[0]);
			end
			SLOT_W'(SLOT_RTRG): begin
				slot_kind = KIND_RTRIG;
				slot_x    = trig_q15(trig_q[1]);
			end
			default: begin
				slot_kind = KIND_BUTTON;
				slot_idx  = 4'(pos_q - SLOT_W'(SLOT_BTN));
				slot_pr   = derived_q[slot_idx];
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slider_q <= DEAD_ZONE_RST;
			level_q  <= TRIG_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEAD_ZONE:  slider_q <= cfg_data;
				CFG_TRIG_LEVEL: level_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer and per-player history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= '0;
			pos_q   <= '0;
			for (int p = 0; p < NUM_PLAYERS; p++) begin
				prev_q[p]    <= '0;
				present_q[p] <= 1'b0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && pl_ok) begin
						op_q  <= '0;
						pos_q <= '0;
						if (connected) begin
							prev_q[player]    <= derived;
							present_q[player] <= 1'b1;
							state_q           <= ST_START;
						end else if (was_present) begin
							present_q[player] <= 1'b0;
							state_q           <= ST_EMIT;
						end
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						if (op_q == OP_W'(NUM_OPS - 1)) begin
							state_q <= ST_EMIT;
						end else begin
							op_q    <= op_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				ST_EMIT: begin
					if (!en_q[pos_q]) begin
						pos_q <= pos_q + 1'b1;
					end else if (out_free) begin
						if (slot_last) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// poll payload and divide results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			player_q  <= player;
			detach_q  <= !connected;
			axis_q[0] <= left_stick_x;
			axis_q[1] <= left_stick_y;
			axis_q[2] <= right_stick_x;
			axis_q[3] <= right_stick_y;
			trig_q[0] <= left_trigger;
			trig_q[1] <= right_trigger;
			dz_q      <= slider_q * slider_q;
			derived_q <= derived;
			if (connected) begin
				en_q <= {diff, 4'hF, !was_present};
			end else begin
				en_q <= {{(NUM_SLOTS - 1){1'b0}}, was_present};
			end
		end
		if (state_q == ST_START) begin
			zero_q <= op_zero;
			neg_q  <= op_neg;
		end
		if ((state_q == ST_WAIT) && div_done) begin
			val_q[op_q] <= op_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			kind_q           <= slot_kind;
			player_res_q     <= player_q;
			value_x_q        <= slot_x;
			value_y_q        <= slot_y;
			button_index_q   <= slot_idx;
			button_pressed_q <= slot_pr;
			last_q           <= slot_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign player_res     = player_res_q;
	assign value_x        = value_x_q;
	assign value_y        = value_y_q;
	assign button_index   = button_index_q;
	assign button_pressed = button_pressed_q;
	assign last           = last_q;

endmodule
`default_nettype wire
